@@ rtl/core/sam_pkg.sv @@
// Shared types and constants of the scan alert mode controller.
// Used by every module in rtl/core; depends on nothing else.
package sam_pkg;

  localparam int unsigned LineBytesDefault = 96;
  localparam int unsigned PrefixBytes      = 8;
  localparam int unsigned QueueDepthDefault = 4;

  localparam int unsigned OpW      = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned ElapsedW = 17;

  localparam logic [CfgW-1:0] ScanTimeoutReset = 16'd15000;
  localparam logic [CfgW-1:0] MatchHoldReset   = 16'd5000;
  localparam logic [CfgW-1:0] NomatchHoldReset = 16'd1000;
  localparam logic [CfgW-1:0] PanicHoldReset   = 16'd5000;
  localparam logic [CfgW-1:0] NeterrHoldReset  = 16'd3000;

  localparam logic [ByteW-1:0] CharLf  = 8'h0A;
  localparam logic [ByteW-1:0] CharCr  = 8'h0D;
  localparam logic [ByteW-1:0] CharOne = 8'h31;

  localparam int unsigned      KwResultLen = 7;
  localparam int unsigned      KwErrLen    = 4;
  localparam logic [55:0]      KwResult    = "RESULT:";
  localparam logic [31:0]      KwErr       = "ERR:";

  typedef enum logic [OpW-1:0] {
    OP_TICK     = 3'd0,
    OP_SCAN     = 3'd1,
    OP_PANIC    = 3'd2,
    OP_RX_BYTE  = 3'd3,
    OP_RX_ERROR = 3'd4
  } sam_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCAN_TIMEOUT = 3'd0,
    CFG_MATCH_HOLD   = 3'd1,
    CFG_NOMATCH_HOLD = 3'd2,
    CFG_PANIC_HOLD   = 3'd3,
    CFG_NETERR_HOLD  = 3'd4
  } sam_cfg_e;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_SCANNING = 3'd1,
    MODE_MATCH    = 3'd2,
    MODE_NOMATCH  = 3'd3,
    MODE_PANIC    = 3'd4,
    MODE_NETERR   = 3'd5
  } sam_mode_e;

  typedef enum logic [2:0] {
    MSG_NONE     = 3'd0,
    MSG_PANIC    = 3'd1,
    MSG_SCANNING = 3'd2,
    MSG_NETERR   = 3'd3,
    MSG_MATCH    = 3'd4,
    MSG_NOMATCH  = 3'd5
  } sam_msg_e;

  // Classified event handed from the line front end to the mode engine.
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_TICK    = 3'd1,
    EV_SCAN    = 3'd2,
    EV_PANIC   = 3'd3,
    EV_MATCH   = 3'd4,
    EV_NOMATCH = 3'd5,
    EV_NETERR  = 3'd6
  } sam_event_e;

  typedef struct packed {
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;
  } sam_queue_ctrl_t;

  typedef struct packed {
    sam_mode_e mode;
    logic      capture;
    sam_msg_e  msg;
  } sam_result_t;

endpackage

@@ rtl/core/sam_front.sv @@
// Front end: accepts input beats, assembles link lines and classifies each beat into an event.
// Depends on sam_pkg.
module sam_front import sam_pkg::*; #(
  parameter int unsigned LineBytes = LineBytesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [OpW-1:0]   operation_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             queue_full_i,
  output logic             push_o,
  output sam_event_e       event_o
);

  localparam int unsigned LenW = $clog2(LineBytes);
  localparam int unsigned PfxIdxW = $clog2(PrefixBytes);

  logic [LenW-1:0]  line_len_q, line_len_d;
  logic [ByteW-1:0] prefix_q [PrefixBytes];
  logic             pfx_we;
  logic [PfxIdxW-1:0] pfx_idx;
  logic             is_eol;
  logic             result_hit, err_hit, one_hit;
  logic             accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign push_o     = accept;
  assign is_eol     = (rx_byte_i == CharLf) || (rx_byte_i == CharCr);
  assign pfx_idx    = line_len_q[PfxIdxW-1:0];

  assign result_hit = (line_len_q >= LenW'(KwResultLen)) &&
                      ({prefix_q[0], prefix_q[1], prefix_q[2], prefix_q[3],
                        prefix_q[4], prefix_q[5], prefix_q[6]} == KwResult);
  assign one_hit    = (line_len_q >= LenW'(PrefixBytes)) && (prefix_q[7] == CharOne);
  assign err_hit    = (line_len_q >= LenW'(KwErrLen)) &&
                      ({prefix_q[0], prefix_q[1], prefix_q[2], prefix_q[3]} == KwErr);

  always_comb begin
    line_len_d = line_len_q;
    pfx_we     = 1'b0;
    event_o    = EV_NONE;
    unique case (operation_i)
      OP_TICK:  event_o = EV_TICK;
      OP_SCAN:  event_o = EV_SCAN;
      OP_PANIC: event_o = EV_PANIC;
      OP_RX_BYTE: begin
        if (is_eol) begin
          if (line_len_q != '0) begin
            line_len_d = '0;
            if (result_hit) begin
              event_o = one_hit ? EV_MATCH : EV_NOMATCH;
            end else if (err_hit) begin
              event_o = EV_NETERR;
            end
          end
        end else if (line_len_q < LenW'(LineBytes - 1)) begin
          pfx_we     = (line_len_q < LenW'(PrefixBytes));
          line_len_d = line_len_q + 1'b1;
        end else begin
          line_len_d = '0;
        end
      end
      OP_RX_ERROR: line_len_d = '0;
      default: event_o = EV_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q <= '0;
    end else if (accept) begin
      line_len_q <= line_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pfx_we) begin
      prefix_q[pfx_idx] <= rx_byte_i;
    end
  end

endmodule

@@ rtl/core/sam_queue.sv @@
// Short event queue between the front end and the mode engine.
// Depends on sam_pkg.
module sam_queue import sam_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sam_event_e      push_event_i,
  output sam_event_e      pop_event_o,
  input  logic            push_i,
  input  logic            pop_i,
  output sam_queue_ctrl_t ctrl_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  sam_event_e      slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            full, empty;

  assign full        = (count_q == CntW'(Depth));
  assign empty       = (count_q == '0);
  assign pop_event_o = slots_q[rd_ptr_q];

  always_comb begin
    ctrl_o.push  = push_i;
    ctrl_o.pop   = pop_i;
    ctrl_o.full  = full;
    ctrl_o.empty = empty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_event_i;
    end
  end

  // No push into a full queue without a pop, and no pop from an empty one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full || pop_i)
    else $error("sam_queue: push while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty)
    else $error("sam_queue: pop while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("sam_queue: count out of range");

endmodule

@@ rtl/core/sam_back.sv @@
// Mode engine: applies queued events, runs the per-mode timeouts and holds the result register.
// Also holds the timeout and hold configuration. Depends on sam_pkg.
module sam_back import sam_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  sam_event_e         event_i,
  input  logic               queue_empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sam_result_t        result_o
);

  localparam logic [ElapsedW-1:0] ElapsedMax = '1;

  logic [CfgW-1:0]     scan_timeout_q, match_hold_q, nomatch_hold_q;
  logic [CfgW-1:0]     panic_hold_q, neterr_hold_q;
  sam_mode_e           mode_q, mode_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  sam_msg_e            msg_d;
  logic                capture_d;
  logic                out_valid_q;
  sam_result_t         result_q;
  logic                pop;

  assign pop         = !queue_empty_i && (!out_valid_q || out_ready_i);
  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  always_comb begin
    mode_d    = mode_q;
    elapsed_d = elapsed_q;
    msg_d     = MSG_NONE;
    capture_d = 1'b0;
    unique case (event_i)
      EV_NONE: ;
      EV_TICK: begin
        if (elapsed_q != ElapsedMax) begin
          elapsed_d = elapsed_q + 1'b1;
        end
      end
      EV_SCAN: begin
        if (mode_q == MODE_IDLE) begin
          mode_d    = MODE_SCANNING;
          elapsed_d = '0;
          msg_d     = MSG_SCANNING;
          capture_d = 1'b1;
        end
      end
      EV_PANIC: begin
        mode_d    = MODE_PANIC;
        elapsed_d = '0;
        msg_d     = MSG_PANIC;
      end
      EV_MATCH: begin
        mode_d    = MODE_MATCH;
        elapsed_d = '0;
        msg_d     = MSG_MATCH;
      end
      EV_NOMATCH: begin
        mode_d    = MODE_NOMATCH;
        elapsed_d = '0;
        msg_d     = MSG_NOMATCH;
      end
      EV_NETERR: begin
        mode_d    = MODE_NETERR;
        elapsed_d = '0;
        msg_d     = MSG_NETERR;
      end
      default: ;
    endcase

    // A mode entered by this beat has a zero count, so at most one timeout fires.
    unique case (mode_d)
      MODE_SCANNING: begin
        if (elapsed_d > {1'b0, scan_timeout_q}) begin
          mode_d    = MODE_NETERR;
          elapsed_d = '0;
          msg_d     = MSG_NETERR;
        end
      end
      MODE_MATCH: begin
        if (elapsed_d > {1'b0, match_hold_q}) begin
          mode_d    = MODE_IDLE;
          elapsed_d = '0;
        end
      end
      MODE_NOMATCH: begin
        if (elapsed_d > {1'b0, nomatch_hold_q}) begin
          mode_d    = MODE_IDLE;
          elapsed_d = '0;
        end
      end
      MODE_PANIC: begin
        if (elapsed_d > {1'b0, panic_hold_q}) begin
          mode_d    = MODE_IDLE;
          elapsed_d = '0;
        end
      end
      MODE_NETERR: begin
        if (elapsed_d > {1'b0, neterr_hold_q}) begin
          mode_d    = MODE_IDLE;
          elapsed_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_timeout_q <= ScanTimeoutReset;
      match_hold_q   <= MatchHoldReset;
      nomatch_hold_q <= NomatchHoldReset;
      panic_hold_q   <= PanicHoldReset;
      neterr_hold_q  <= NeterrHoldReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCAN_TIMEOUT: scan_timeout_q <= cfg_data_i;
        CFG_MATCH_HOLD:   match_hold_q   <= cfg_data_i;
        CFG_NOMATCH_HOLD: nomatch_hold_q <= cfg_data_i;
        CFG_PANIC_HOLD:   panic_hold_q   <= cfg_data_i;
        CFG_NETERR_HOLD:  neterr_hold_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        mode_q    <= mode_d;
        elapsed_q <= elapsed_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      result_q.mode    <= mode_d;
      result_q.capture <= capture_d;
      result_q.msg     <= msg_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && result_q.capture |-> result_q.mode == MODE_SCANNING &&
      result_q.msg == MSG_SCANNING)
    else $error("sam_back: capture request outside scanning entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && (result_q.msg == MSG_PANIC) |-> result_q.mode == MODE_PANIC)
    else $error("sam_back: panic message without panic mode");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      mode_q != $past(mode_q) |-> elapsed_q == '0)
    else $error("sam_back: elapsed count not cleared on mode change");

endmodule

@@ rtl/core/scan_alert_mode_controller.sv @@
// Scan alert mode controller: a line front end feeds classified events through a short
// queue into the mode engine that drives lamps, buzzer, capture and phone messages.
// The block accepts one beat per cycle while the queue has room and returns exactly one
// result beat for every input beat. The front end classifies in the cycle of acceptance,
// the queue absorbs up to QueueDepth beats while the result side stalls, and the mode
// engine, when not stalled, handles one queued event per cycle into its result register.
// There is no start-up sweep: the block takes beats from the first cycle after reset.
module scan_alert_mode_controller import sam_pkg::*; #(
  parameter int unsigned LineBytes  = LineBytesDefault,
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpW-1:0]     operation_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         current_mode_o,
  output logic               led_green_o,
  output logic               led_yellow_o,
  output logic               led_red_o,
  output logic               buzzer_on_o,
  output logic               capture_request_o,
  output logic [2:0]         phone_message_o
);

  sam_event_e      push_event, pop_event;
  logic            push, pop;
  sam_queue_ctrl_t queue_ctrl;
  sam_result_t     result;

  sam_front #(
    .LineBytes (LineBytes)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .rx_byte_i    (rx_byte_i),
    .queue_full_i (queue_ctrl.full),
    .push_o       (push),
    .event_o      (push_event)
  );

  sam_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_event_i (push_event),
    .pop_event_o  (pop_event),
    .push_i       (push),
    .pop_i        (pop),
    .ctrl_o       (queue_ctrl)
  );

  sam_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .event_i       (pop_event),
    .queue_empty_i (queue_ctrl.empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_o      (result)
  );

  assign current_mode_o    = result.mode;
  assign led_green_o       = (result.mode == MODE_IDLE) || (result.mode == MODE_NOMATCH);
  assign led_yellow_o      = (result.mode == MODE_SCANNING) || (result.mode == MODE_NETERR);
  assign led_red_o         = (result.mode == MODE_MATCH) || (result.mode == MODE_PANIC) ||
                             (result.mode == MODE_NETERR);
  assign buzzer_on_o       = (result.mode == MODE_MATCH) || (result.mode == MODE_PANIC);
  assign capture_request_o = result.capture;
  assign phone_message_o   = result.msg;

endmodule
